>>> design/sha1md_pkg.sv
`default_nettype none

package sha1md_pkg;

    localparam int WordW     = 32;
    localparam int NumRounds = 80;
    localparam int RoundW    = 7;
    localparam int FillW     = 4;
    localparam int LenW      = 61;
    localparam int SchedLen  = 16;

    typedef logic [WordW-1:0]  word_t;
    typedef logic [4:0][WordW-1:0] chain_t;

    // element 0 is H0
    localparam chain_t InitChain = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                    32'hEFCDAB89, 32'h67452301};

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [7:0] PadByte = 8'h80;
    localparam word_t      PadWord = {PadByte, 24'h000000};

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FIN   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // controls for the round unit
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic reinit;
    } rnd_ctl_t;

    // controls for the message schedule
    typedef struct packed {
        logic  push;
        logic  step;
        word_t word;
    } sched_ctl_t;

    function automatic word_t rotl(input word_t v, input int unsigned s);
        rotl = (v << s) | (v >> (WordW - s));
    endfunction

endpackage

`default_nettype wire

>>> design/sha1md_sched.sv
`default_nettype none

module sha1md_sched
    import sha1md_pkg::*;
(
    input  wire logic       clk,
    input  wire sched_ctl_t ctl,
    output word_t           wt
);

    word_t w_reg [SchedLen];
    word_t shift_in;
    word_t expand;

    // W[t+16] from the window W[t..t+15]
    assign expand   = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign shift_in = ctl.push ? ctl.word : expand;
    assign wt       = w_reg[0];

    // shift line: pushes fill from the top, rounds slide the window
    always_ff @(posedge clk)
    begin
        if (ctl.push || ctl.step)
        begin
            for (int i = 0; i < SchedLen - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[SchedLen-1] <= shift_in;
        end
    end

endmodule

`default_nettype wire

>>> design/sha1md_round.sv
`default_nettype none

module sha1md_round
    import sha1md_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rnd_ctl_t          ctl,
    input  wire logic [RoundW-1:0] round,
    input  wire word_t             wt,
    output chain_t                 chain
);

    chain_t chain_reg;
    word_t  a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t  f_val;
    word_t  k_val;
    word_t  temp;

    // round function and constant by round group
    always_comb
    begin
        if (round < RoundW'(20))
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (round < RoundW'(40))
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (round < RoundW'(60))
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    assign temp  = rotl(a_reg, 5) + f_val + e_reg + k_val + wt;
    assign chain = chain_reg;

    // working variables, one round per cycle while ctl.step is set
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (ctl.step)
        begin
            a_reg <= temp;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= InitChain;
        end
        else if (ctl.reinit)
        begin
            chain_reg <= InitChain;
        end
        else if (ctl.finish)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

endmodule

`default_nettype wire

>>> design/sha1_message_digest_unit.sv
// SHA-1 message digest unit.
// Input channel (data_valid / data_stall): one big-endian message word per
// item with byte_count and is_last. Words before the last always carry four
// bytes; the last item carries 0 to 4 (counts above four act as four).
// Output channel (digest_valid / digest_stall): one 160-bit digest per
// message, digest_a first. The digest sits in an output register, so the
// next message can be streamed in while a digest waits to be taken.
// Flow: a word that does not finish a block is taken in the cycle it is
// offered. The word that fills a block holds data_stall high while the block
// is compressed: 80 rounds through the single round unit, then the chaining add.
// After the last item the padding words are pushed one per cycle (up to 16)
// followed by one or two compressions, and then the digest is loaded.
// If digest_stall holds a previous digest, a finished message waits in the
// done state with data_stall high until that digest is taken.
// Reset: chaining value returns to the SHA-1 initial values, counts clear,
// no digest is valid and the block is ready for a new message.
`default_nettype none

module sha1_message_digest_unit
    import sha1md_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        data_valid,
    output logic             data_stall,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        is_last,
    output logic             digest_valid,
    input  wire logic        digest_stall,
    output logic [31:0]      digest_a,
    output logic [31:0]      digest_b,
    output logic [31:0]      digest_c,
    output logic [31:0]      digest_d,
    output logic [31:0]      digest_e
);

    state_t              state_reg, state_next;
    logic [RoundW-1:0]   round_cnt_reg, round_cnt_next;
    logic [FillW-1:0]    fill_reg, fill_next;
    logic [LenW-1:0]     bytes_reg, bytes_next;
    logic                extra_reg, extra_next;
    logic                hi_done_reg, hi_done_next;
    logic                lo_done_reg, lo_done_next;
    logic                padding_reg, padding_next;
    logic                dv_reg, dv_next;
    chain_t              digest_reg;

    rnd_ctl_t            rc;
    sched_ctl_t          sc;
    word_t               wt;
    chain_t              chain;
    logic                dig_load;
    logic [2:0]          count_sat;
    word_t               first_word;
    word_t               pad_word;
    logic [63:0]         len_bits;

    sha1md_sched u_sched
    (
        .clk (clk),
        .ctl (sc),
        .wt  (wt)
    );

    sha1md_round u_round
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rc),
        .round (round_cnt_reg),
        .wt    (wt),
        .chain (chain)
    );

    // last word: keep leading bytes, append the pad byte
    assign count_sat = (byte_count > 3'd4) ? 3'd4 : byte_count;

    always_comb
    begin
        case (count_sat)
            3'd0:    first_word = PadWord;
            3'd1:    first_word = {data_word[31:24], PadByte, 16'h0000};
            3'd2:    first_word = {data_word[31:16], PadByte, 8'h00};
            3'd3:    first_word = {data_word[31:8], PadByte};
            default: first_word = data_word;
        endcase
    end

    // padding words: deferred pad byte, zeros, then the bit length
    assign len_bits = {bytes_reg, 3'b000};

    always_comb
    begin
        if (extra_reg)
        begin
            pad_word = PadWord;
        end
        else if (fill_reg == FillW'(14))
        begin
            pad_word = len_bits[63:32];
        end
        else if (fill_reg == FillW'(15) && hi_done_reg)
        begin
            pad_word = len_bits[31:0];
        end
        else
        begin
            pad_word = '0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        round_cnt_next = round_cnt_reg;
        fill_next      = fill_reg;
        bytes_next     = bytes_reg;
        extra_next     = extra_reg;
        hi_done_next   = hi_done_reg;
        lo_done_next   = lo_done_reg;
        padding_next   = padding_reg;
        rc             = '0;
        sc             = '0;
        dig_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (data_valid)
                begin
                    sc.push   = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    if (is_last)
                    begin
                        sc.word      = first_word;
                        bytes_next   = bytes_reg + LenW'(count_sat);
                        extra_next   = (count_sat == 3'd4);
                        padding_next = 1'b1;
                    end
                    else
                    begin
                        sc.word    = data_word;
                        bytes_next = bytes_reg + LenW'(4);
                    end
                    if (fill_reg == FillW'(15))
                    begin
                        rc.load        = 1'b1;
                        round_cnt_next = '0;
                        state_next     = ST_ROUND;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                sc.push    = 1'b1;
                sc.word    = pad_word;
                fill_next  = fill_reg + 1'b1;
                extra_next = 1'b0;
                if (!extra_reg && fill_reg == FillW'(14))
                begin
                    hi_done_next = 1'b1;
                end
                if (!extra_reg && fill_reg == FillW'(15) && hi_done_reg)
                begin
                    lo_done_next = 1'b1;
                end
                if (fill_reg == FillW'(15))
                begin
                    rc.load        = 1'b1;
                    round_cnt_next = '0;
                    state_next     = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                sc.step        = 1'b1;
                rc.step        = 1'b1;
                round_cnt_next = round_cnt_reg + 1'b1;
                if (round_cnt_reg == RoundW'(NumRounds - 1))
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                rc.finish = 1'b1;
                if (lo_done_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (padding_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DONE:
            begin
                if (!dv_reg || !digest_stall)
                begin
                    dig_load     = 1'b1;
                    rc.reinit    = 1'b1;
                    bytes_next   = '0;
                    fill_next    = '0;
                    extra_next   = 1'b0;
                    hi_done_next = 1'b0;
                    lo_done_next = 1'b0;
                    padding_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        dv_next = dv_reg;
        if (dig_load)
        begin
            dv_next = 1'b1;
        end
        else if (dv_reg && !digest_stall)
        begin
            dv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_cnt_reg <= '0;
            fill_reg      <= '0;
            bytes_reg     <= '0;
            extra_reg     <= 1'b0;
            hi_done_reg   <= 1'b0;
            lo_done_reg   <= 1'b0;
            padding_reg   <= 1'b0;
            dv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_cnt_reg <= round_cnt_next;
            fill_reg      <= fill_next;
            bytes_reg     <= bytes_next;
            extra_reg     <= extra_next;
            hi_done_reg   <= hi_done_next;
            lo_done_reg   <= lo_done_next;
            padding_reg   <= padding_next;
            dv_reg        <= dv_next;
        end
    end

    // digest payload
    always_ff @(posedge clk)
    begin
        if (dig_load)
        begin
            digest_reg <= chain;
        end
    end

    assign data_stall   = (state_reg != ST_IDLE);
    assign digest_valid = dv_reg;
    assign digest_a     = digest_reg[0];
    assign digest_b     = digest_reg[1];
    assign digest_c     = digest_reg[2];
    assign digest_d     = digest_reg[3];
    assign digest_e     = digest_reg[4];

    // checks
    a_digest_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> $past(state_reg == ST_DONE))
        else $error("digest raised outside the done state");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> round_cnt_reg < RoundW'(NumRounds))
        else $error("round counter out of range");

    a_done_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> fill_reg == '0 && hi_done_reg && padding_reg)
        else $error("done with a partly filled block");

    a_digest_held: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest_a))
        else $error("stalled digest changed");

endmodule

`default_nettype wire
